// ----- rtl/marie_pkg.sv -----
package marie_pkg;

  // Memory depth in words; a power of two from 256 to 4096.
  localparam int MEM_WORDS = 4096;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int WORD_W    = 16;
  localparam int PC_W      = 12;

  // Instruction opcodes, word bits 15..12
  localparam logic [3:0] OP_JNS    = 4'h0;
  localparam logic [3:0] OP_LOAD   = 4'h1;
  localparam logic [3:0] OP_STORE  = 4'h2;
  localparam logic [3:0] OP_ADD    = 4'h3;
  localparam logic [3:0] OP_SUBT   = 4'h4;
  localparam logic [3:0] OP_INPUT  = 4'h5;
  localparam logic [3:0] OP_OUTPUT = 4'h6;
  localparam logic [3:0] OP_HALT   = 4'h7;
  localparam logic [3:0] OP_SKIP   = 4'h8;
  localparam logic [3:0] OP_JUMP   = 4'h9;
  localparam logic [3:0] OP_CLEAR  = 4'hA;
  localparam logic [3:0] OP_ADDI   = 4'hB;
  localparam logic [3:0] OP_JUMPI  = 4'hC;
  localparam logic [3:0] OP_LOADI  = 4'hD;
  localparam logic [3:0] OP_STOREI = 4'hE;
  localparam logic [3:0] OP_NOP    = 4'hF;

  // Skip condition selector, address bits 11..10
  localparam logic [1:0] SK_NEG  = 2'b00;
  localparam logic [1:0] SK_ZERO = 2'b01;
  localparam logic [1:0] SK_POS  = 2'b10;

  // Item kinds on in_opcode
  localparam logic ITEM_WRITE = 1'b0;
  localparam logic ITEM_EXEC  = 1'b1;

  typedef enum logic [1:0] {
    ADDR_IN,   // write item address
    ADDR_PC,   // instruction fetch
    ADDR_RD    // low bits of the last word read
  } addr_sel_t;

  typedef enum logic [1:0] {
    WD_IN,     // write item data
    WD_PC1,    // advanced program counter (JNS)
    WD_ACC     // accumulator
  } wd_sel_t;

  typedef struct packed {
    logic      accept;
    logic      mem_we;
    logic      mem_re;
    addr_sel_t addr_sel;
    wd_sel_t   wd_sel;
    logic      latch_op;
    logic      upd_dec;
    logic      upd_oper;
    logic      upd_ind;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    logic [3:0] rd_op;
    logic [3:0] op;
    logic       halted;
  } st_t;

endpackage

// ----- rtl/marie_ctrl.sv -----
module marie_ctrl import marie_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_opcode,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  st_t  st,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_OPER = 3'd2;
  localparam logic [2:0] S_IND  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_full_r, out_full_nxt;
  logic       accept;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_full_r;
  assign out_free  = !out_full_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.addr_sel = ADDR_IN;
    cmd.wd_sel   = WD_IN;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          state_nxt  = S_FIN;
          if (!st.halted) begin
            if (in_opcode == ITEM_WRITE) begin
              cmd.mem_we = 1'b1;
            end else begin
              cmd.mem_re   = 1'b1;
              cmd.addr_sel = ADDR_PC;
              state_nxt    = S_DEC;
            end
          end
        end
      end
      S_DEC: begin
        cmd.upd_dec  = 1'b1;
        cmd.latch_op = 1'b1;
        cmd.addr_sel = ADDR_RD;
        state_nxt    = S_FIN;
        unique case (st.rd_op)
          OP_JNS: begin
            cmd.mem_we = 1'b1;
            cmd.wd_sel = WD_PC1;
          end
          OP_STORE: begin
            cmd.mem_we = 1'b1;
            cmd.wd_sel = WD_ACC;
          end
          OP_LOAD, OP_ADD, OP_SUBT, OP_ADDI, OP_JUMPI, OP_LOADI, OP_STOREI: begin
            cmd.mem_re = 1'b1;
            state_nxt  = S_OPER;
          end
          default: ;
        endcase
      end
      S_OPER: begin
        cmd.upd_oper = 1'b1;
        cmd.addr_sel = ADDR_RD;
        cmd.wd_sel   = WD_ACC;
        state_nxt    = S_FIN;
        unique case (st.op)
          OP_ADDI, OP_LOADI: begin
            cmd.mem_re = 1'b1;
            state_nxt  = S_IND;
          end
          OP_STOREI: cmd.mem_we = 1'b1;
          default: ;
        endcase
      end
      S_IND: begin
        cmd.upd_ind = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_full_nxt = cmd.load_out ? 1'b1 : (out_full_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_full_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_full_r <= out_full_nxt;
    end
  end

  a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mem_we && cmd.mem_re))
    else $error("memory read and write in one cycle");

  a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && st.halted) |-> (!cmd.mem_we && !cmd.mem_re))
    else $error("halted machine touched memory");

  a_dec_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cmd.mem_re) |=> (state_r == S_DEC))
    else $error("fetch not followed by decode");

  a_ind_op: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IND) |-> (st.op == OP_ADDI || st.op == OP_LOADI))
    else $error("indirect read for a direct opcode");

endmodule

// ----- rtl/marie_dp.sv -----
module marie_dp import marie_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output st_t                      st,
  input  logic [PC_W-1:0]          in_address,
  input  logic [WORD_W-1:0]        in_data,
  input  logic signed [WORD_W-1:0] in_in_value,
  output logic [PC_W-1:0]          out_pc,
  output logic signed [WORD_W-1:0] out_acc,
  output logic                     out_out_valid,
  output logic signed [WORD_W-1:0] out_out_value,
  output logic                     out_used_input,
  output logic                     out_halted
);

  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic [WORD_W-1:0] rd_data_r;

  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic              halt_r, halt_nxt;
  logic              outv_r, outv_nxt;
  logic              used_r, used_nxt;
  logic [3:0]        op_r, op_nxt;
  logic [WORD_W-1:0] inv_r, inv_nxt;

  logic [PC_W-1:0]   out_pc_r;
  logic [WORD_W-1:0] out_acc_r;
  logic              out_outv_r;
  logic [WORD_W-1:0] out_value_r;
  logic              out_used_r;
  logic              out_halt_r;

  logic [MEM_AW-1:0] mem_addr;
  logic [WORD_W-1:0] wdata;
  logic [3:0]        rd_op;
  logic [PC_W-1:0]   x;
  logic [PC_W-1:0]   pc_inc;
  logic [1:0]        skip_sel;
  logic              skip;

  assign rd_op    = rd_data_r[WORD_W-1 -: 4];
  assign x        = rd_data_r[PC_W-1:0];
  assign pc_inc   = pc_r + 1'b1;
  assign skip_sel = x[PC_W-1 -: 2];

  always_comb begin
    unique case (skip_sel)
      SK_NEG:  skip = acc_r[WORD_W-1];
      SK_ZERO: skip = (acc_r == '0);
      SK_POS:  skip = !acc_r[WORD_W-1] && (acc_r != '0);
      default: skip = 1'b0;
    endcase
  end

  assign st.rd_op  = rd_op;
  assign st.op     = op_r;
  assign st.halted = halt_r;

  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_IN: mem_addr = in_address[MEM_AW-1:0];
      ADDR_PC: mem_addr = pc_r[MEM_AW-1:0];
      ADDR_RD: mem_addr = rd_data_r[MEM_AW-1:0];
      default: mem_addr = rd_data_r[MEM_AW-1:0];
    endcase
    unique case (cmd.wd_sel)
      WD_IN:   wdata = in_data;
      WD_PC1:  wdata = {{(WORD_W-PC_W){1'b0}}, pc_inc};
      WD_ACC:  wdata = acc_r;
      default: wdata = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem[mem_addr] <= wdata;
    if (cmd.mem_re) rd_data_r <= mem[mem_addr];
  end

  always_comb begin
    pc_nxt   = pc_r;
    acc_nxt  = acc_r;
    halt_nxt = halt_r;
    outv_nxt = outv_r;
    used_nxt = used_r;
    op_nxt   = op_r;
    inv_nxt  = inv_r;
    if (cmd.accept) begin
      outv_nxt = 1'b0;
      used_nxt = 1'b0;
      inv_nxt  = in_in_value;
    end
    if (cmd.latch_op) op_nxt = rd_op;
    if (cmd.upd_dec) begin
      pc_nxt = pc_inc;
      unique case (rd_op)
        OP_JNS:    pc_nxt = x + 1'b1;
        OP_INPUT: begin
          acc_nxt  = inv_r;
          used_nxt = 1'b1;
        end
        OP_OUTPUT: outv_nxt = 1'b1;
        OP_HALT:   halt_nxt = 1'b1;
        OP_SKIP:   if (skip) pc_nxt = pc_inc + 1'b1;
        OP_JUMP:   pc_nxt = x;
        OP_CLEAR:  acc_nxt = '0;
        default: ;
      endcase
    end
    if (cmd.upd_oper) begin
      unique case (op_r)
        OP_LOAD:  acc_nxt = rd_data_r;
        OP_ADD:   acc_nxt = acc_r + rd_data_r;
        OP_SUBT:  acc_nxt = acc_r - rd_data_r;
        OP_JUMPI: pc_nxt  = x;
        default: ;
      endcase
    end
    if (cmd.upd_ind) begin
      unique case (op_r)
        OP_ADDI:  acc_nxt = acc_r + rd_data_r;
        OP_LOADI: acc_nxt = rd_data_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      acc_r  <= '0;
      halt_r <= 1'b0;
      outv_r <= 1'b0;
      used_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      acc_r  <= acc_nxt;
      halt_r <= halt_nxt;
      outv_r <= outv_nxt;
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    inv_r <= inv_nxt;
    if (cmd.load_out) begin
      out_pc_r    <= pc_r;
      out_acc_r   <= acc_r;
      out_outv_r  <= outv_r;
      out_value_r <= outv_r ? acc_r : '0;
      out_used_r  <= used_r;
      out_halt_r  <= halt_r;
    end
  end

  assign out_pc         = out_pc_r;
  assign out_acc        = $signed(out_acc_r);
  assign out_out_valid  = out_outv_r;
  assign out_out_value  = $signed(out_value_r);
  assign out_used_input = out_used_r;
  assign out_halted     = out_halt_r;

endmodule

// ----- rtl/marie_cpu_step.sv -----
// MARIE accumulator processor, one item per transfer. A write item
// (in_opcode 0) stores in_data at in_address and is how a program is loaded;
// an execute item (in_opcode 1) fetches and runs one instruction at the
// program counter and reports pc, acc and the OUTPUT/INPUT/HALT flags.
// Every access goes through one synchronous single-port memory, so an item
// is taken in, waits on each read it needs and then posts its result once
// the output register is free. A write item, or any item once halted, reads
// nothing; JNS, STORE and others without an operand read wait on the fetch
// only, LOAD, ADD, SUBT, JUMPI and STOREI on an operand read too, ADDI and
// LOADI on a pointer read as well. One item is in flight at a time;
// a result waits in the output register while the next item is taken.
// Main memory has no reset: reading a word never written returns garbage.
module marie_cpu_step import marie_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_opcode,
  input  logic [PC_W-1:0]          in_address,
  input  logic [WORD_W-1:0]        in_data,
  input  logic signed [WORD_W-1:0] in_in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PC_W-1:0]          out_pc,
  output logic signed [WORD_W-1:0] out_acc,
  output logic                     out_out_valid,
  output logic signed [WORD_W-1:0] out_out_value,
  output logic                     out_used_input,
  output logic                     out_halted
);

  cmd_t cmd;
  st_t  st;

  // Sequencer: fetch, operand and pointer steps, result post
  marie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Registers, memory and result register
  marie_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_address     (in_address),
    .in_data        (in_data),
    .in_in_value    (in_in_value),
    .out_pc         (out_pc),
    .out_acc        (out_acc),
    .out_out_valid  (out_out_valid),
    .out_out_value  (out_out_value),
    .out_used_input (out_used_input),
    .out_halted     (out_halted)
  );

endmodule

// ----- tb/sv/marie_cpu_step_mirror_pkg.sv -----
package marie_cpu_step_mirror_pkg;
  import marie_pkg::*;

  // One result of the block, as the mirror expects it
  typedef struct packed {
    logic [PC_W-1:0]   pc;
    logic [WORD_W-1:0] acc;
    logic              emit;
    logic [WORD_W-1:0] emit_value;
    logic              took_input;
    logic              halted;
  } marie_report_t;

  // Architectural copy of the machine: memory, PC, AC and halt flag,
  // plus the queue of results still owed by the block.
  class marie_machine_mirror;
    bit [WORD_W-1:0] mem [MEM_WORDS];
    bit              written [MEM_WORDS];
    bit [PC_W-1:0]   pc;
    bit [WORD_W-1:0] acc;
    bit              halted;
    marie_report_t   due_reports [$];
    int unsigned     items_taken;
    int unsigned     writes_taken;
    int unsigned     instrs_run;
    int unsigned     outputs_seen;
    int unsigned     reports_checked;
    int unsigned     mismatches;
    bit [15:0]       ops_run;

    function new();
      pc = '0;
      acc = '0;
      halted = 1'b0;
    endfunction

    function int unsigned slot(bit [PC_W-1:0] a);
      return a % MEM_WORDS;
    endfunction

    function bit [WORD_W-1:0] read_word(bit [PC_W-1:0] a);
      return mem[slot(a)];
    endfunction

    function void put_word(bit [PC_W-1:0] a, bit [WORD_W-1:0] v);
      mem[slot(a)] = v;
      written[slot(a)] = 1'b1;
    endfunction

    function bit is_written(bit [PC_W-1:0] a);
      return written[slot(a)];
    endfunction

    // Report the first word the next instruction would read that holds
    // nothing yet; 0 when the next execute item is safe.
    function bit find_unwritten(output logic [PC_W-1:0] a);
      bit [WORD_W-1:0] w;
      bit [3:0]        op;
      a = pc;
      if (halted) return 1'b0;
      if (!is_written(pc)) return 1'b1;
      w = read_word(pc);
      op = w[15:12];
      a = w[11:0];
      if (!(op inside {OP_LOAD, OP_ADD, OP_SUBT, OP_ADDI, OP_JUMPI, OP_LOADI, OP_STOREI}))
        return 1'b0;
      if (!is_written(a)) return 1'b1;
      if (!(op inside {OP_ADDI, OP_LOADI})) return 1'b0;
      w = read_word(a);
      a = w[PC_W-1:0];
      return !is_written(a);
    endfunction

    function void run_instruction(bit [WORD_W-1:0] inval, inout marie_report_t r);
      bit [WORD_W-1:0]        word;
      bit [WORD_W-1:0]        ptr;
      bit [3:0]               op;
      bit [PC_W-1:0]          x;
      bit signed [WORD_W-1:0] sac;
      bit [1:0]               sel;
      word = read_word(pc);
      op = word[15:12];
      x = word[11:0];
      sac = acc;
      ptr = read_word(x);
      pc = pc + 1'b1;
      ops_run[op] = 1'b1;
      instrs_run++;
      case (op)
        OP_JNS: begin
          put_word(x, {4'h0, pc});
          pc = x + 1'b1;
        end
        OP_LOAD:   acc = ptr;
        OP_STORE:  put_word(x, acc);
        OP_ADD:    acc = acc + ptr;
        OP_SUBT:   acc = acc - ptr;
        OP_INPUT: begin
          acc = inval;
          r.took_input = 1'b1;
        end
        OP_OUTPUT: begin
          r.emit = 1'b1;
          r.emit_value = acc;
          outputs_seen++;
        end
        OP_HALT:   halted = 1'b1;
        OP_SKIP: begin
          sel = x[11:10];
          if ((sel == SK_NEG && sac < 0) || (sel == SK_ZERO && sac == 0) ||
              (sel == SK_POS && sac > 0))
            pc = pc + 1'b1;
        end
        OP_JUMP:   pc = x;
        OP_CLEAR:  acc = '0;
        OP_ADDI:   acc = acc + read_word(ptr[PC_W-1:0]);
        OP_JUMPI:  pc = ptr[PC_W-1:0];
        OP_LOADI:  acc = read_word(ptr[PC_W-1:0]);
        OP_STOREI: put_word(ptr[PC_W-1:0], acc);
        default: ;
      endcase
    endfunction

    // Note one accepted input transfer and queue the result it must cause
    function void take_item(logic kind, logic [PC_W-1:0] addr, logic [WORD_W-1:0] data,
                            logic [WORD_W-1:0] inval);
      marie_report_t r;
      r = '0;
      items_taken++;
      if (!halted) begin
        if (kind == ITEM_WRITE) begin
          put_word(addr, data);
          writes_taken++;
        end else begin
          run_instruction(inval, r);
        end
      end
      r.pc = pc;
      r.acc = acc;
      r.halted = halted;
      due_reports.push_back(r);
    endfunction

    function void check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        mismatches++;
      end
    endfunction

    // Check one accepted result against the oldest one owed
    function void compare_report(logic [PC_W-1:0] pc_o, logic [WORD_W-1:0] acc_o,
                                 logic emit_o, logic [WORD_W-1:0] emit_value_o,
                                 logic took_o, logic halted_o);
      marie_report_t e;
      if (due_reports.size() == 0) begin
        $error("result with nothing owed: pc %h acc %h", pc_o, acc_o);
        mismatches++;
        return;
      end
      e = due_reports.pop_front();
      reports_checked++;
      check_field("pc", {4'h0, e.pc}, {4'h0, pc_o});
      check_field("acc", e.acc, acc_o);
      check_field("out_valid", {15'h0, e.emit}, {15'h0, emit_o});
      check_field("out_value", e.emit_value, emit_value_o);
      check_field("used_input", {15'h0, e.took_input}, {15'h0, took_o});
      check_field("halted", {15'h0, e.halted}, {15'h0, halted_o});
    endfunction
  endclass

endpackage

// ----- tb/sv/marie_cpu_step_test.sv -----
module marie_cpu_step_test;
  import marie_pkg::*;
  import marie_cpu_step_mirror_pkg::*;

  // Transfers in total; the tail after HALT takes the last few
  localparam int unsigned ITEM_TARGET = 450;
  localparam int unsigned HALT_TAIL   = 8;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_opcode;
  logic [PC_W-1:0]          in_address;
  logic [WORD_W-1:0]        in_data;
  logic signed [WORD_W-1:0] in_in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [PC_W-1:0]          out_pc;
  logic signed [WORD_W-1:0] out_acc;
  logic                     out_out_valid;
  logic signed [WORD_W-1:0] out_out_value;
  logic                     out_used_input;
  logic                     out_halted;

  marie_machine_mirror sb = new();

  marie_cpu_step dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_address     (in_address),
    .in_data        (in_data),
    .in_in_value    (in_in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pc         (out_pc),
    .out_acc        (out_acc),
    .out_out_valid  (out_out_valid),
    .out_out_value  (out_out_value),
    .out_used_input (out_used_input),
    .out_halted     (out_halted)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("marie_cpu_step_test: errors");
    $finish;
  end

  // Idle length for either side: mostly none, some short, a few long.
  // A calm phase returns no idling at all.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Data words: half fully random, half small so pointers land near code
  function automatic logic [WORD_W-1:0] pick_data();
    if ($urandom_range(0, 1) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 47));
  endfunction

  function automatic logic [PC_W-1:0] pick_address();
    if ($urandom_range(0, 1) == 0) return 12'($urandom);
    return 12'($urandom_range(0, 47));
  endfunction

  // INPUT values lean on the sign extremes and zero
  function automatic logic [WORD_W-1:0] pick_input();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random instruction, never HALT: HALT ends the machine until reset, so
  // it is saved for the close of the run. Operands mostly stay in a small
  // window so jumps keep the PC near code already loaded.
  function automatic logic [WORD_W-1:0] fresh_instruction();
    logic [3:0]      op;
    logic [PC_W-1:0] x;
    do op = 4'($urandom_range(0, 15)); while (op == OP_HALT);
    x = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 47));
    if (op == OP_SKIP) x[11:10] = 2'($urandom);
    return {op, x};
  endfunction

  // Offer one transfer and hold it until accepted, then idle for a while.
  // Valid is only lowered when a gap follows, so it never drops and rises
  // again in one step.
  task automatic transfer_item(input logic kind, input logic [PC_W-1:0] addr,
                               input logic [WORD_W-1:0] data, input logic [WORD_W-1:0] inval);
    int unsigned gap;
    in_valid    <= 1'b1;
    in_opcode   <= kind;
    in_address  <= addr;
    in_data     <= data;
    in_in_value <= inval;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_item(kind, addr, data, inval);
    gap = pick_gap(((sb.items_taken / 50) % 4) == 2);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic poke_word(input logic [PC_W-1:0] addr, input logic [WORD_W-1:0] data);
    transfer_item(ITEM_WRITE, addr, data, 16'($urandom));
  endtask

  // Address and data are don't-care on an execute transfer; scramble them
  task automatic step_cpu(input logic [WORD_W-1:0] inval);
    transfer_item(ITEM_EXEC, 12'($urandom), 16'($urandom), inval);
  endtask

  // Load every word the next instruction will read and that holds nothing yet
  task automatic fill_operands();
    logic [PC_W-1:0] hole;
    while (sb.find_unwritten(hole)) poke_word(hole, pick_data());
  endtask

  // Place one instruction at the PC, back its operands, execute it
  task automatic run_word(input logic [WORD_W-1:0] word, input logic [WORD_W-1:0] inval);
    poke_word(sb.pc, word);
    fill_operands();
    step_cpu(inval);
  endtask

  // Result side: check each accepted result, stall at random, and once
  // hold off for a long stretch so the block backs up into its input.
  initial begin : result_side
    int unsigned hold_left;
    int unsigned cycle_no;
    bit          long_done;
    hold_left = 0;
    cycle_no  = 0;
    long_done = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (out_valid && !out_stall)
        sb.compare_report(out_pc, out_acc, out_out_valid, out_out_value,
                          out_used_input, out_halted);
      cycle_no++;
      if (!long_done && sb.reports_checked >= 150) begin
        long_done = 1'b1;
        hold_left = 80;
      end
      if (hold_left == 0) hold_left = pick_gap(((cycle_no / 400) % 4) == 1);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  // Input side: reset, directed program, random programs, HALT and its tail
  initial begin : input_side
    logic [WORD_W-1:0] w;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_opcode   <= ITEM_WRITE;
    in_address  <= '0;
    in_data     <= '0;
    in_in_value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every opcode but STORE and HALT, sign extremes, wrapping arithmetic, all four
    // skip selectors including the one that never skips, indirection
    // through the top word, and the return address wrapping from 0xFFF to 0.
    poke_word(12'hFFF, 16'hFFFF);
    run_word({OP_INPUT, 12'h000}, 16'h7FFF);
    run_word({OP_ADD, 12'hFFF}, 16'h0000);      // wraps to 0x7FFE
    run_word({OP_SKIP, 12'h800}, 16'h0000);     // AC > 0, skip
    run_word({OP_OUTPUT, 12'h000}, 16'h0000);
    run_word({OP_INPUT, 12'h000}, 16'h8000);
    run_word({OP_SKIP, 12'h000}, 16'h0000);     // AC < 0, skip
    run_word({OP_LOADI, 12'hFFF}, 16'h0000);    // pointer to itself
    run_word({OP_CLEAR, 12'h000}, 16'h0000);
    run_word({OP_SKIP, 12'h400}, 16'h0000);     // AC == 0, skip
    run_word({OP_SKIP, 12'hC00}, 16'h0000);     // never skips
    run_word({OP_SUBT, 12'hFFF}, 16'h0000);     // 0 - 0xFFFF borrows to 1
    run_word({OP_STOREI, 12'hFFF}, 16'h0000);
    run_word({OP_ADDI, 12'hFFF}, 16'h0000);
    run_word({OP_JUMP, 12'hFFE}, 16'h0000);
    run_word({OP_LOAD, 12'h000}, 16'h0000);
    run_word({OP_JNS, 12'h030}, 16'h0000);      // return address wraps to 0
    run_word({OP_JUMPI, 12'h030}, 16'h0000);
    run_word({OP_NOP, 12'hABC}, 16'h0000);

    // Random: mostly fetch-execute with a fresh or reused word at the PC,
    // some stray writes anywhere. A stored HALT at the PC gets replaced.
    while (sb.items_taken < ITEM_TARGET - HALT_TAIL) begin
      if ($urandom_range(0, 99) < 12) begin
        poke_word(pick_address(), 16'($urandom));
      end else begin
        w = sb.read_word(sb.pc);
        if (!sb.is_written(sb.pc) || w[15:12] == OP_HALT || $urandom_range(0, 99) < 45)
          poke_word(sb.pc, fresh_instruction());
        fill_operands();
        step_cpu(pick_input());
      end
    end

    // Halt, then check that writes and steps are both ignored
    run_word({OP_HALT, 12'($urandom)}, pick_input());
    repeat (3) begin
      poke_word(12'($urandom), 16'($urandom));
      step_cpu(pick_input());
    end
    in_valid <= 1'b0;

    // Drain what is owed, then watch a little longer for strays
    while (sb.due_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d transfers: %0d memory writes, %0d instructions, %0d OUTPUTs",
             sb.items_taken, sb.writes_taken, sb.instrs_run, sb.outputs_seen);
    $display("opcodes executed %b, %0d results compared, %0d mismatches",
             sb.ops_run, sb.reports_checked, sb.mismatches);
    if (sb.mismatches == 0)
      $display("marie_cpu_step_test: clean");
    else
      $display("marie_cpu_step_test: errors");
    $finish;
  end

endmodule
